/* hw/rtl/preemptive_priority_scheduler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Short forms for the concurrent checks used inside the RTL datapath module.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Types, codes and constants shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int PPS_MAX_PROCS = 16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_req;
  } pps_in_t;

  typedef struct packed {
    logic        idle;
    logic [3:0]  ran_slot;
    logic        finished;
    logic [31:0] finish_time;
    logic        all_done;
  } pps_out_t;

  // One row of the process table.
  typedef struct packed {
    logic [15:0] arr;
    logic [15:0] rem;
    logic [7:0]  pri;
  } pps_row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pps_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic commit;
  } pps_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } pps_status_t;

endpackage

/* hw/rtl/pps_in_if.sv */
// ----------------------------------------------------------------------------
// pps_in_if
// Input channel of the scheduler: load and tick transactions.
// ----------------------------------------------------------------------------
interface pps_in_if import pps_pkg::*; ();
  logic    valid;
  logic    ready;
  pps_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/pps_out_if.sv */
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel of the scheduler: one transaction per tick.
// ----------------------------------------------------------------------------
interface pps_out_if import pps_pkg::*; ();
  logic     valid;
  logic     ready;
  pps_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for the scheduler: accepts transactions, runs the slot scan and
// commits the tick result.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_func,
  output logic        in_ready,
  input  pps_status_t status,
  output pps_cmd_t    cmd
);

  pps_state_t state;
  pps_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (in_func == FUNC_TICK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && (in_func == FUNC_LOAD);
        cmd.start = in_valid && (in_func == FUNC_TICK);
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/pps_datapath.sv */
// ----------------------------------------------------------------------------
// pps_datapath
// Process table, one-slot-per-cycle selection unit, time counter and
// result register of the scheduler.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_assert.svh"

module pps_datapath import pps_pkg::*; #(
  parameter int MAX_PROCS = PPS_MAX_PROCS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_wdata,
  input  pps_in_t         in_data,
  input  pps_cmd_t        cmd,
  output pps_status_t     status,
  pps_out_if.source       sched_out
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  // Table memory; arrival and priority are meaningful only once loaded.
  pps_row_t               mem [MAX_PROCS];
  logic [MAX_PROCS-1:0]   loaded;

  logic [4:0]    process_count;
  logic [31:0]   time_counter;
  logic [CW-1:0] scan_cnt;
  logic [CW-1:0] nz_count;
  logic [CW-1:0] used;
  logic          rd_pending;
  logic [IW-1:0] rd_idx;
  pps_row_t      rd_row;
  logic          rd_loaded;

  logic          found;
  logic [IW-1:0] best_idx;
  logic [15:0]   best_arr;
  logic [15:0]   best_rem;
  logic [7:0]    best_pri;

  logic          out_vld;
  pps_out_t      out_data;

  logic [8:0]    slot_ext;
  logic          slot_ok;
  logic          issue;
  logic          live;
  logic          cand;
  logic          better;
  logic          take;
  logic          fin;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  pps_row_t      mem_wdata;

  // A count above the table depth means the whole table.
  assign used = (9'(process_count) > 9'(MAX_PROCS)) ? CW'(MAX_PROCS) : CW'(process_count);

  assign slot_ext = 9'(in_data.slot);
  assign slot_ok  = slot_ext < 9'(MAX_PROCS);
  assign issue    = cmd.scan && (scan_cnt != used);

  // Evaluation of the row read in the previous cycle. A strict compare keeps
  // the lower slot on a full tie.
  assign live   = rd_pending && rd_loaded && (rd_row.rem != 16'd0);
  assign cand   = live && ({16'd0, rd_row.arr} <= time_counter);
  assign better = !found || (rd_row.pri < best_pri) ||
                  ((rd_row.pri == best_pri) && (rd_row.arr < best_arr));
  assign take   = cmd.scan && cand && better;

  assign fin = found && (best_rem == 16'd1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = '{arr: best_arr, rem: best_rem - 16'd1, pri: best_pri};
    if (cmd.load) begin
      mem_we    = slot_ok;
      mem_waddr = slot_ext[IW-1:0];
      mem_wdata = '{arr: in_data.arrival_time, rem: in_data.burst_length,
                    pri: in_data.priority_req};
    end else if (cmd.commit) begin
      mem_we = found;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_row    <= mem[scan_cnt[IW-1:0]];
      rd_loaded <= loaded[scan_cnt[IW-1:0]];
      rd_idx    <= scan_cnt[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= 5'd1;
      time_counter  <= '0;
      loaded        <= '0;
      scan_cnt      <= '0;
      nz_count      <= '0;
      rd_pending    <= 1'b0;
      found         <= 1'b0;
      out_vld       <= 1'b0;
    end else begin
      if (cfg_we) begin
        process_count <= cfg_wdata;
      end
      if (cmd.load && slot_ok) begin
        loaded[slot_ext[IW-1:0]] <= 1'b1;
      end
      if (cmd.start) begin
        scan_cnt   <= '0;
        nz_count   <= '0;
        rd_pending <= 1'b0;
        found      <= 1'b0;
      end else if (cmd.scan) begin
        rd_pending <= issue;
        if (issue) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
        if (live) begin
          nz_count <= nz_count + CW'(1);
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        time_counter <= time_counter + 32'd1;
        out_vld      <= 1'b1;
      end else if (sched_out.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx <= rd_idx;
      best_arr <= rd_row.arr;
      best_rem <= rd_row.rem;
      best_pri <= rd_row.pri;
    end
    if (cmd.commit) begin
      out_data.idle        <= !found;
      out_data.ran_slot    <= found ? 4'(best_idx) : 4'd0;
      out_data.finished    <= fin;
      out_data.finish_time <= time_counter + 32'd1;
      out_data.all_done    <= (nz_count == CW'(fin));
    end
  end

  assign status.scan_done = scan_cnt == used;
  assign status.out_busy  = out_vld && !sched_out.ready;

  assign sched_out.valid = out_vld;
  assign sched_out.data  = out_data;

  `PPS_ASSERT_NEXT(a_commit_gives_result, cmd.commit, sched_out.valid, "commit left no result")
  `PPS_ASSERT_NEXT(a_time_steps_once, cmd.commit, time_counter == $past(time_counter) + 32'd1, "time counter did not advance by one")
  `PPS_ASSERT_IMP(a_pick_counted, cmd.commit && found, nz_count != '0, "picked process missing from live count")
  `PPS_ASSERT_IMP(a_pick_in_use, cmd.commit && found, CW'(best_idx) < used, "picked slot outside the slots in use")

endmodule

/* hw/rtl/preemptive_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a table of process slots.
// ----------------------------------------------------------------------------
// A load transaction writes one slot (arrival, burst, priority) and returns
// nothing; loads to a slot at or above MAX_PROCS are dropped. A tick
// transaction scans the slots in use (process_count, capped at MAX_PROCS)
// one per cycle through a single compare unit reading the table memory, so
// the time from accepting a tick to accepting the next transaction grows
// with the number of slots in use, limited by the one read port of the
// table. The result sits in an output register, so the next transaction is
// accepted while it waits; a tick only stalls if the previous result is
// still untaken when its own is ready. The table needs no clearing pass
// after reset: per-slot load flags make unloaded slots read as finished.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int MAX_PROCS = PPS_MAX_PROCS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  pps_in_if.sink     sched_in,
  pps_out_if.source  sched_out
);

  pps_cmd_t    cmd;
  pps_status_t status;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sched_in.valid),
    .in_func  (sched_in.data.func),
    .in_ready (sched_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pps_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (sched_in.data),
    .cmd       (cmd),
    .status    (status),
    .sched_out (sched_out)
  );

endmodule

/* tb/preemptive_priority_scheduler_test.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_test
// Self-checking bench for the preemptive priority scheduler. Load and tick
// transactions go in through a queue-fed driver with random gaps, and the
// result channel is stalled at random. A cycle-free predictor of the process
// table works out the outcome of every tick, and the monitor compares each
// result with the oldest prediction. The run starts with a short directed
// sequence, then runs random schedules under a range of process counts.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_test;
  import pps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned SETTLE_CYCLES = 25;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  pps_in_if  sched_in_bus ();
  pps_out_if sched_out_bus ();

  preemptive_priority_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sched_in  (sched_in_bus),
    .sched_out (sched_out_bus)
  );

  // Predicted copy of the process table and the scheduler state.
  logic [15:0] arr_tab  [PPS_MAX_PROCS];
  logic [15:0] left_tab [PPS_MAX_PROCS];
  logic [7:0]  rank_tab [PPS_MAX_PROCS];
  logic [31:0] tick_now;
  logic [4:0]  slot_limit;

  pps_in_t  pending_items [$];
  pps_out_t results_due [$];

  int unsigned items_made;
  int unsigned error_count;
  logic        in_taken;
  int unsigned in_gap;
  int unsigned in_calm;
  int unsigned out_stall;
  int unsigned out_calm;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sched_in_bus.valid = 1'b0;
    sched_in_bus.data = '0;
    sched_out_bus.ready = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    in_calm = 0;
    out_stall = 0;
    out_calm = 0;
    items_made = 0;
    error_count = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("preemptive_priority_scheduler_test NOT OK");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < PPS_MAX_PROCS; i++) begin
      arr_tab[i] = '0;
      left_tab[i] = '0;
      rank_tab[i] = '0;
    end
    tick_now = '0;
    slot_limit = 5'd1;
  endfunction

  function automatic void load_slot(pps_in_t item);
    arr_tab[item.slot] = item.arrival_time;
    left_tab[item.slot] = item.burst_length;
    rank_tab[item.slot] = item.priority_req;
  endfunction

  // One tick: pick the best ready process, run it, and advance time.
  function automatic pps_out_t run_tick();
    pps_out_t    res;
    int unsigned used_n;
    int unsigned pick;
    logic        found;
    logic        all_clear;
    used_n = (slot_limit > PPS_MAX_PROCS) ? PPS_MAX_PROCS : slot_limit;
    found = 1'b0;
    pick = 0;
    for (int unsigned i = 0; i < used_n; i++) begin
      if (left_tab[i] != 0 && {16'd0, arr_tab[i]} <= tick_now) begin
        if (!found || rank_tab[i] < rank_tab[pick] ||
            (rank_tab[i] == rank_tab[pick] && arr_tab[i] < arr_tab[pick])) begin
          found = 1'b1;
          pick = i;
        end
      end
    end
    tick_now = tick_now + 32'd1;
    res = '0;
    res.idle = !found;
    if (found) begin
      left_tab[pick] = left_tab[pick] - 16'd1;
      res.ran_slot = pick[3:0];
      res.finished = (left_tab[pick] == 0);
    end
    res.finish_time = tick_now;
    all_clear = 1'b1;
    for (int unsigned i = 0; i < used_n; i++) begin
      if (left_tab[i] != 0) all_clear = 1'b0;
    end
    res.all_done = all_clear;
    return res;
  endfunction

  function automatic void check_field(string tag, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      error_count++;
      if (error_count <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want_v, got_v);
      end
    end
  endfunction

  // Monitor: predicts on accepted inputs and checks accepted results.
  always @(posedge clk) begin : check_proc
    pps_out_t want;
    pps_out_t got;
    if (rst) begin
      clear_table();
      in_taken <= 1'b0;
    end else begin
      if (cfg_we) slot_limit = cfg_wdata;
      in_taken <= sched_in_bus.valid && sched_in_bus.ready;
      if (sched_in_bus.valid && sched_in_bus.ready) begin
        if (sched_in_bus.data.func == FUNC_TICK) begin
          results_due.push_back(run_tick());
        end else begin
          load_slot(sched_in_bus.data);
        end
      end
      if (sched_out_bus.valid && sched_out_bus.ready) begin
        got = sched_out_bus.data;
        if (results_due.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: result with nothing expected, got %0h", $time, got);
          end
        end else begin
          want = results_due.pop_front();
          check_field("idle", 32'(want.idle), 32'(got.idle));
          check_field("ran_slot", 32'(want.ran_slot), 32'(got.ran_slot));
          check_field("finished", 32'(want.finished), 32'(got.finished));
          check_field("finish_time", want.finish_time, got.finish_time);
          check_field("all_done", 32'(want.all_done), 32'(got.all_done));
        end
      end
    end
  end

  // Driver: holds an item until it is taken, then waits out a random gap.
  always @(negedge clk) begin : drive_proc
    logic    next_valid;
    pps_in_t next_data;
    next_valid = sched_in_bus.valid;
    next_data = sched_in_bus.data;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!sched_in_bus.valid || in_taken) begin
      next_valid = 1'b0;
      if (in_calm > 0) in_calm--;
      else if ($urandom_range(0, 299) == 0) in_calm = $urandom_range(50, 200);
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_items.size() > 0) begin
        next_data = pending_items.pop_front();
        next_valid = 1'b1;
        in_gap = (in_calm > 0) ? 0 : pick_gap();
      end
    end
    sched_in_bus.valid <= next_valid;
    sched_in_bus.data <= next_data;
  end

  // Result side: ready drops for random stretches.
  always @(negedge clk) begin : stall_proc
    logic next_ready;
    if (out_calm > 0) out_calm--;
    else if ($urandom_range(0, 299) == 0) out_calm = $urandom_range(50, 200);
    if (out_stall > 0) begin
      out_stall--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
      out_stall = (out_calm > 0) ? 0 : pick_gap();
    end
    sched_out_bus.ready <= next_ready;
  end

  function automatic void add_load(logic [3:0] s, logic [15:0] a, logic [15:0] b,
                                   logic [7:0] p);
    pps_in_t item;
    item.func = FUNC_LOAD;
    item.slot = s;
    item.arrival_time = a;
    item.burst_length = b;
    item.priority_req = p;
    pending_items.push_back(item);
    items_made++;
  endfunction

  function automatic void add_tick();
    pps_in_t item;
    item.func = FUNC_TICK;
    item.slot = 4'($urandom_range(0, 15));
    item.arrival_time = 16'($urandom_range(0, 65535));
    item.burst_length = 16'($urandom_range(0, 65535));
    item.priority_req = 8'($urandom_range(0, 255));
    pending_items.push_back(item);
    items_made++;
  endfunction

  // Stray load: mostly into unused slots, sometimes breaking a live schedule.
  function automatic void add_stray_load(int unsigned used);
    logic [3:0]  s;
    logic [15:0] b;
    if (used < PPS_MAX_PROCS && $urandom_range(0, 2) != 0) s = 4'($urandom_range(used, 15));
    else s = 4'($urandom_range(0, 15));
    b = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
    add_load(s, 16'($urandom_range(0, 65535)), b, 8'($urandom_range(0, 255)));
  endfunction

  // Wait until the block has drained, plus the longest tick latency.
  task automatic settle();
    while (pending_items.size() != 0 || sched_in_bus.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned v;
    int unsigned used;
    int unsigned total;
    int unsigned k;
    int unsigned j;
    int unsigned tmp;
    int unsigned order [PPS_MAX_PROCS];
    logic        wide;
    logic [31:0] base;
    logic [15:0] b;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Nothing loaded yet: the tick is idle and everything counts as done.
    add_tick();
    add_load(4'd0, 16'd0, 16'd2, 8'd5);
    add_tick();
    add_tick();
    settle();
    set_count(5'd0);
    add_tick();
    settle();
    // A count above the table size uses every slot.
    set_count(5'd31);
    add_load(4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_load(4'd3, 16'd0, 16'd1, 8'd0);
    add_load(4'd4, 16'd0, 16'd1, 8'd0);
    add_load(4'd5, 16'd5, 16'd3, 8'd0);
    add_load(4'd6, 16'd0, 16'd0, 8'd0);
    add_load(4'd7, 16'd0, 16'd2, 8'd128);
    add_load(4'd8, 16'd7, 16'd1, 8'd1);
    repeat (3) add_tick();
    // Reloading a running process restarts it.
    add_load(4'd5, 16'd0, 16'd2, 8'd0);
    repeat (3) add_tick();
    add_load(4'd15, 16'd0, 16'd1, 8'd255);
    repeat (6) add_tick();

    while (items_made < ITEM_TARGET) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 5) v = 0;
      else if (r < 12) v = $urandom_range(17, 31);
      else if (r < 22) v = 16;
      else if (r < 35) v = $urandom_range(7, 15);
      else v = $urandom_range(1, 6);
      set_count(v[4:0]);
      used = (v > PPS_MAX_PROCS) ? PPS_MAX_PROCS : v;
      base = tick_now;
      wide = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PPS_MAX_PROCS; k++) order[k] = k;
      for (k = used; k > 1; k--) begin
        j = $urandom_range(0, k - 1);
        tmp = order[k - 1];
        order[k - 1] = order[j];
        order[j] = tmp;
      end
      total = 0;
      for (k = 0; k < used; k++) begin
        b = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 30)) : 16'($urandom_range(1, 5));
        add_load(order[k][3:0], 16'(base + $urandom_range(0, 8)), b,
                 wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3)));
        total += b;
        if ($urandom_range(0, 3) == 0) add_tick();
        if ($urandom_range(0, 24) == 0) add_stray_load(used);
      end
      repeat (total + 10 + $urandom_range(0, 4)) begin
        add_tick();
        if ($urandom_range(0, 24) == 0) add_stray_load(used);
      end
    end

    settle();
    if (error_count == 0) begin
      $display("preemptive_priority_scheduler_test OK");
    end else begin
      $display("preemptive_priority_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule
